>>> src/assert_macros.svh
// Assertion helpers included by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check sampled on clk and suspended while arst_n is low.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Concurrent check sampled on clk that stays active through reset.
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> src/mplb_pkg.sv
`default_nettype none

package mplb_pkg;

	// Width of every timing configuration register.
	localparam int unsigned TICK_W = 16;
	// Width of the pattern length register.
	localparam int unsigned LEN_W = 6;
	// Width of a symbol index.
	localparam int unsigned POS_W = 5;
	// Number of symbol slots in the pattern register.
	localparam int unsigned SLOTS = 32;

	// Reset values of the timing registers.
	localparam logic [TICK_W-1:0] DOT_RESET   = 16'd250;
	localparam logic [TICK_W-1:0] DASH_RESET  = 16'd750;
	localparam logic [TICK_W-1:0] SPACE_RESET = 16'd1000;
	localparam logic [TICK_W-1:0] GAP_RESET   = 16'd100;

	// Symbol codes packed two bits each into the pattern register.
	typedef enum logic [1:0] {
		SYM_DOT   = 2'd0,
		SYM_DASH  = 2'd1,
		SYM_SPACE = 2'd2,
		SYM_BLANK = 2'd3
	} sym_t;

	// Register indexes; register i sits at byte address 8*i.
	typedef enum logic [2:0] {
		REG_SYMBOLS = 3'd0,
		REG_LENGTH  = 3'd1,
		REG_DOT     = 3'd2,
		REG_DASH    = 3'd3,
		REG_SPACE   = 3'd4,
		REG_GAP     = 3'd5
	} reg_idx_t;

endpackage

`default_nettype wire

>>> src/morse_pattern_led_blinker.sv
// Morse-style pattern blinker for one LED.
// The input channel (in_valid/in_ready, field restart) takes one request per
// timer tick, normally once a millisecond. Each accepted request advances the
// blink sequencer by one tick and produces exactly one result on the output
// channel (out_valid/out_ready, fields led_lit, symbol_position, in_gap).
// A result is valid in the cycle after its request is accepted. The block
// takes one request per cycle while the receiver keeps out_ready high; the
// only loop is the state register update.
// The result register is the sequencer state itself. While a result waits,
// a new request is still taken in the same cycle that out_ready is high; if
// the receiver stalls, in_ready drops and the state and result hold.
// The APB-style port sets the pattern and timing; registers sit at 8*i and are to be
// written by the user only while the block is idle; the block itself does not enforce this. pready is always high.
// Reset clears the sequencer to the first symbol with the LED off and the
// countdown at zero, restores the default timings and empties the pattern.
`default_nettype none

`include "assert_macros.svh"

module morse_pattern_led_blinker #(
	parameter int unsigned MAX_SYMBOLS = 32,
	parameter int unsigned TIMER_WIDTH = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Configuration port.
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [5:0]  paddr,
	input  wire logic [63:0] pwdata,
	output logic      [63:0] prdata,
	output logic             pready,
	// Tick requests.
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        restart,
	// Results.
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             led_lit,
	output logic [mplb_pkg::POS_W-1:0] symbol_position,
	output logic             in_gap
);

	localparam logic [mplb_pkg::LEN_W-1:0] MaxLen = mplb_pkg::LEN_W'(MAX_SYMBOLS);
	localparam logic [32:0] TimerMax = (33'd1 << TIMER_WIDTH) - 33'd1;

	// Configuration registers.
	logic [mplb_pkg::SLOTS-1:0][1:0]   pattern_q;
	logic [mplb_pkg::LEN_W-1:0]        length_q;
	logic [mplb_pkg::TICK_W-1:0]       dot_q;
	logic [mplb_pkg::TICK_W-1:0]       dash_q;
	logic [mplb_pkg::TICK_W-1:0]       space_q;
	logic [mplb_pkg::TICK_W-1:0]       gap_q;

	// Sequencer state, which doubles as the result register.
	logic                              gap_phase_q;
	logic [mplb_pkg::POS_W-1:0]        position_q;
	logic [TIMER_WIDTH-1:0]            remaining_q;
	logic                              led_q;
	logic                              out_valid_q;

	// Next-state values.
	logic                              gap_phase_d;
	logic [mplb_pkg::POS_W-1:0]        position_d;
	logic [TIMER_WIDTH-1:0]            remaining_d;
	logic                              led_d;

	logic                              in_accept;
	logic                              cfg_write;
	mplb_pkg::reg_idx_t                reg_idx;
	logic [mplb_pkg::LEN_W-1:0]        eff_len;
	logic [mplb_pkg::POS_W-1:0]        pos_eff;
	mplb_pkg::sym_t                    sym;

	// Saturate a tick count into the timer width.
	function automatic logic [TIMER_WIDTH-1:0] timer_load(
		input logic [mplb_pkg::TICK_W-1:0] ticks
	);
		logic [32:0] wide;
		wide = 33'(ticks);
		if (wide > TimerMax) begin
			return '1;
		end
		return wide[TIMER_WIDTH-1:0];
	endfunction

	// Next position after p, wrapping at the effective length.
	function automatic logic [mplb_pkg::POS_W-1:0] advance(
		input logic [mplb_pkg::POS_W-1:0] p,
		input logic [mplb_pkg::LEN_W-1:0] len
	);
		logic [mplb_pkg::LEN_W-1:0] nxt;
		nxt = {1'b0, p} + 6'd1;
		if (nxt >= len) begin
			return '0;
		end
		return nxt[mplb_pkg::POS_W-1:0];
	endfunction

	// Handshakes.
	assign in_accept = in_valid && in_ready;
	assign in_ready  = !out_valid_q || out_ready;
	assign cfg_write = psel && penable && pwrite && pready;
	assign reg_idx   = mplb_pkg::reg_idx_t'(paddr[5:3]);
	assign pready    = 1'b1;

	// Configuration register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q <= '0;
			length_q  <= '0;
			dot_q     <= mplb_pkg::DOT_RESET;
			dash_q    <= mplb_pkg::DASH_RESET;
			space_q   <= mplb_pkg::SPACE_RESET;
			gap_q     <= mplb_pkg::GAP_RESET;
		end else if (cfg_write) begin
			unique case (reg_idx)
				mplb_pkg::REG_SYMBOLS: pattern_q <= pwdata;
				mplb_pkg::REG_LENGTH:  length_q  <= pwdata[mplb_pkg::LEN_W-1:0];
				mplb_pkg::REG_DOT:     dot_q     <= pwdata[mplb_pkg::TICK_W-1:0];
				mplb_pkg::REG_DASH:    dash_q    <= pwdata[mplb_pkg::TICK_W-1:0];
				mplb_pkg::REG_SPACE:   space_q   <= pwdata[mplb_pkg::TICK_W-1:0];
				mplb_pkg::REG_GAP:     gap_q     <= pwdata[mplb_pkg::TICK_W-1:0];
				default: ;
			endcase
		end
	end

	// Register read mux.
	always_comb begin
		unique case (reg_idx)
			mplb_pkg::REG_SYMBOLS: prdata = pattern_q;
			mplb_pkg::REG_LENGTH:  prdata = 64'(length_q);
			mplb_pkg::REG_DOT:     prdata = 64'(dot_q);
			mplb_pkg::REG_DASH:    prdata = 64'(dash_q);
			mplb_pkg::REG_SPACE:   prdata = 64'(space_q);
			mplb_pkg::REG_GAP:     prdata = 64'(gap_q);
			default:               prdata = '0;
		endcase
	end

	// Effective length, current symbol slot and its code.
	assign eff_len = (length_q > MaxLen) ? MaxLen : length_q;
	assign pos_eff = ({1'b0, position_q} >= eff_len) ? '0 : position_q;
	assign sym     = mplb_pkg::sym_t'(pattern_q[pos_eff]);

	// One tick of the sequencer.
	always_comb begin
		gap_phase_d = gap_phase_q;
		position_d  = position_q;
		remaining_d = remaining_q;
		led_d       = led_q;
		if (restart) begin
			gap_phase_d = 1'b0;
			position_d  = '0;
			remaining_d = '0;
			led_d       = 1'b0;
		end else if (remaining_q != '0) begin
			remaining_d = remaining_q - {{(TIMER_WIDTH-1){1'b0}}, 1'b1};
			if (eff_len == '0) begin
				led_d = 1'b0;
			end
		end else if (eff_len == '0) begin
			led_d = 1'b0;
		end else if (!gap_phase_q) begin
			position_d = pos_eff;
			case (sym)
				mplb_pkg::SYM_SPACE: begin
					led_d       = 1'b0;
					remaining_d = timer_load(space_q);
					position_d  = advance(pos_eff, eff_len);
				end
				mplb_pkg::SYM_DOT: begin
					led_d       = 1'b1;
					remaining_d = timer_load(dot_q);
					gap_phase_d = 1'b1;
				end
				mplb_pkg::SYM_DASH: begin
					led_d       = 1'b1;
					remaining_d = timer_load(dash_q);
					gap_phase_d = 1'b1;
				end
				default: begin
					led_d       = 1'b0;
					remaining_d = '0;
					gap_phase_d = 1'b1;
				end
			endcase
		end else begin
			remaining_d = timer_load(gap_q);
			led_d       = 1'b0;
			gap_phase_d = 1'b0;
			position_d  = advance(position_q, eff_len);
		end
	end

	// State and result registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_phase_q <= 1'b0;
			position_q  <= '0;
			remaining_q <= '0;
			led_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_accept) begin
				gap_phase_q <= gap_phase_d;
				position_q  <= position_d;
				remaining_q <= remaining_d;
				led_q       <= led_d;
			end
			if (in_accept) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid       = out_valid_q;
	assign led_lit         = led_q;
	assign symbol_position = position_q;
	assign in_gap          = gap_phase_q;

	// An empty pattern never lights the LED.
	`ASSERT_CLK(a_empty_dark, (in_accept && eff_len == '0) |=> !led_q, "LED lit with empty pattern")
	// A gap step always ends dark and back in the symbol phase.
	`ASSERT_CLK(a_gap_step, (in_accept && !restart && remaining_q == '0 && eff_len != '0 && gap_phase_q) |=> (!led_q && !gap_phase_q), "gap step did not darken")
	// A step leaves the position inside the pattern.
	`ASSERT_CLK(a_pos_range, (in_accept && !restart && remaining_q == '0 && eff_len != '0) |=> ({1'b0, position_q} < $past(eff_len)), "position outside pattern")
	// The result must not change while it waits for the receiver.
	`ASSERT_CLK(a_state_hold, (!in_accept) |=> ($stable(position_q) && $stable(led_q) && $stable(remaining_q)), "state moved without a request")

endmodule

`default_nettype wire
